// ----- sv/crgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Reward gate controller package
// Shared types and constants for the reward gate controller.
// ----------------------------------------------------------------------------
package crgc_pkg;

  // Configuration registers.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COIN_GUARD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_MODE    = 2'd2;

  localparam logic [CFG_W-1:0]  OPEN_DURATION_RST = 16'd5000;
  localparam logic [CFG_W-1:0]  COIN_GUARD_RST    = 16'd1000;

  // Training modes.
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;  // gate held open
  localparam logic [MODE_W-1:0] MODE_LAND  = 3'd2;  // open on landing
  localparam logic [MODE_W-1:0] MODE_COIN  = 3'd3;  // pay to open
  localparam logic [MODE_W-1:0] MODE_COIN2 = 3'd4;  // pay to open, last mode

  // Single-bit results of one tick.
  typedef struct packed {
    logic gate_open;
    logic gate_opened;
    logic gate_closed;
    logic bird_present;
    logic bird_landed;
    logic coin_accepted;
  } flags_t;

  // Out-of-range mode codes fall back to the free mode.
  function automatic logic [MODE_W-1:0] legal_mode(input logic [MODE_W-1:0] m);
    logic ok;
    ok = (m >= MODE_FREE) && (m <= MODE_COIN2);
    return ok ? m : MODE_FREE;
  endfunction

endpackage

// ----- sv/crgc_tick.sv -----
// ----------------------------------------------------------------------------
// Reward gate controller tick engine
// Holds the controller state and configuration and works out one tick.
// ----------------------------------------------------------------------------
module crgc_tick #(
  parameter int COIN_BITS  = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [crgc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [crgc_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  fire,
  input  logic                                  perch,
  input  logic                                  strike,
  input  logic                                  button,
  output crgc_pkg::flags_t                      flags,
  output logic [COIN_BITS-1:0]                  coins,
  output logic [crgc_pkg::MODE_W-1:0]           mode_now
);

  localparam int LW = (TIMER_BITS > crgc_pkg::CFG_W) ? TIMER_BITS : crgc_pkg::CFG_W;
  localparam logic [LW-1:0] TMAX = LW'({TIMER_BITS{1'b1}});
  localparam logic [COIN_BITS-1:0] COIN_MAX = {COIN_BITS{1'b1}};

  // Register values beyond the timer range saturate.
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [crgc_pkg::CFG_W-1:0] v);
    logic [LW-1:0] w;
    w = LW'(v);
    return (w > TMAX) ? TIMER_BITS'(TMAX) : TIMER_BITS'(w);
  endfunction

  logic [crgc_pkg::CFG_W-1:0]  open_duration;
  logic [crgc_pkg::CFG_W-1:0]  coin_guard;
  logic [crgc_pkg::MODE_W-1:0] mode_reg, mode_reg_next;
  logic                        gate_state, gate_state_next;
  logic                        close_armed, close_armed_next;
  logic [TIMER_BITS-1:0]       close_countdown, close_countdown_next;
  logic                        bird_flag, bird_flag_next;
  logic [COIN_BITS-1:0]        coin_count, coin_count_next;
  logic [TIMER_BITS-1:0]       guard_countdown, guard_countdown_next;
  logic                        button_prev;
  crgc_pkg::flags_t            flags_next;

  always_comb begin
    logic [TIMER_BITS-1:0] guard_dec;
    logic                  opened, closed, landed, accepted;

    opened = 1'b0;
    closed = 1'b0;
    landed = 1'b0;

    gate_state_next      = gate_state;
    close_armed_next     = close_armed;
    close_countdown_next = close_countdown;
    bird_flag_next       = bird_flag;
    coin_count_next      = coin_count;
    mode_reg_next        = mode_reg;

    // Coin guard runs down first; a strike counts once it has expired.
    guard_dec = (guard_countdown != '0) ? guard_countdown - 1'b1 : guard_countdown;
    accepted  = strike && (guard_dec == '0);
    guard_countdown_next = accepted ? timer_load(coin_guard) : guard_dec;
    if (accepted && (coin_count != COIN_MAX)) begin
      coin_count_next = coin_count + 1'b1;
    end

    // A due close always disarms, but only closes an open gate.
    if (close_armed) begin
      if (close_countdown != '0) begin
        close_countdown_next = close_countdown - 1'b1;
      end
      if (close_countdown_next == '0) begin
        closed           = gate_state;
        gate_state_next  = 1'b0;
        close_armed_next = 1'b0;
      end
    end

    if ((mode_reg == crgc_pkg::MODE_FREE) || (mode_reg == crgc_pkg::MODE_LAND)) begin
      if ((mode_reg == crgc_pkg::MODE_FREE) && !gate_state_next) begin
        gate_state_next      = 1'b1;
        opened               = 1'b1;
        close_armed_next     = 1'b0;
        close_countdown_next = '0;
      end
      if (bird_flag) begin
        if (!perch) begin
          bird_flag_next = 1'b0;
        end
      end else if (perch) begin
        bird_flag_next = 1'b1;
        landed         = 1'b1;
        if (mode_reg == crgc_pkg::MODE_LAND) begin
          if (!gate_state_next) begin
            gate_state_next = 1'b1;
            opened          = 1'b1;
          end
          close_armed_next     = 1'b1;
          close_countdown_next = timer_load(open_duration);
        end
      end
    end else begin
      if ((coin_count_next != '0) && !gate_state_next) begin
        coin_count_next      = coin_count_next - 1'b1;
        gate_state_next      = 1'b1;
        opened               = 1'b1;
        close_armed_next     = 1'b1;
        close_countdown_next = timer_load(open_duration);
      end
    end

    // The mode steps on release of the button, after this tick's rule.
    if (button_prev && !button) begin
      mode_reg_next = (mode_reg >= crgc_pkg::MODE_COIN2) ? crgc_pkg::MODE_FREE
                                                         : mode_reg + 1'b1;
    end

    flags_next.gate_open     = gate_state_next;
    flags_next.gate_opened   = opened;
    flags_next.gate_closed   = closed;
    flags_next.bird_present  = bird_flag_next;
    flags_next.bird_landed   = landed;
    flags_next.coin_accepted = accepted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_duration   <= crgc_pkg::OPEN_DURATION_RST;
      coin_guard      <= crgc_pkg::COIN_GUARD_RST;
      mode_reg        <= crgc_pkg::MODE_FREE;
      gate_state      <= 1'b0;
      close_armed     <= 1'b0;
      close_countdown <= '0;
      bird_flag       <= 1'b0;
      coin_count      <= '0;
      guard_countdown <= '0;
      button_prev     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        crgc_pkg::REG_OPEN_DURATION: open_duration <= cfg_data;
        crgc_pkg::REG_COIN_GUARD:    coin_guard    <= cfg_data;
        crgc_pkg::REG_START_MODE:
          mode_reg <= crgc_pkg::legal_mode(cfg_data[crgc_pkg::MODE_W-1:0]);
        default: ;
      endcase
    end else if (fire) begin
      mode_reg        <= mode_reg_next;
      gate_state      <= gate_state_next;
      close_armed     <= close_armed_next;
      close_countdown <= close_countdown_next;
      bird_flag       <= bird_flag_next;
      coin_count      <= coin_count_next;
      guard_countdown <= guard_countdown_next;
      button_prev     <= button;
    end
  end

  assign flags    = flags_next;
  assign coins    = coin_count_next;
  assign mode_now = mode_reg_next;

endmodule

// ----- sv/coin_reward_gate_controller.sv -----
// ----------------------------------------------------------------------------
// Coin reward gate controller
// Tick-driven gate, perch, coin and training mode control.
// ----------------------------------------------------------------------------
// One input transaction is one time tick and yields one result transaction.
// The block takes a tick in every cycle in which in_stall is low. The
// combinational tick logic sits between the input register and the result
// register, so a result is presented once its tick has passed both. A result
// held by out_stall stalls the input only once the input register is also
// occupied. Ticks are processed strictly in order, since each one reads the
// state left by the previous tick. The user is to write configuration
// through cfg_write, cfg_index and cfg_data while no tick is in flight (not
// enforced by the block); a write of start_mode also sets the current mode.
module coin_reward_gate_controller #(
  parameter int COIN_BITS  = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [crgc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [crgc_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  perch_pressed,
  input  logic                                  coin_strike,
  input  logic                                  mode_button,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  gate_open,
  output logic                                  gate_opened,
  output logic                                  gate_closed,
  output logic                                  bird_present,
  output logic                                  bird_landed,
  output logic                                  coin_accepted,
  output logic [COIN_BITS-1:0]                  coins_pending,
  output logic [crgc_pkg::MODE_W-1:0]           mode
);

  logic                        a_valid;
  logic                        a_perch, a_strike, a_button;
  logic                        res_take;
  logic                        a_fire;
  logic                        in_take;
  crgc_pkg::flags_t            tick_flags;
  logic [COIN_BITS-1:0]        tick_coins;
  logic [crgc_pkg::MODE_W-1:0] tick_mode;

  assign res_take = !out_valid || !out_stall;
  assign a_fire   = a_valid && res_take;
  assign in_stall = a_valid && !res_take;
  assign in_take  = in_valid && !in_stall;

  crgc_tick #(
    .COIN_BITS (COIN_BITS),
    .TIMER_BITS(TIMER_BITS)
  ) u_tick (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fire     (a_fire),
    .perch    (a_perch),
    .strike   (a_strike),
    .button   (a_button),
    .flags    (tick_flags),
    .coins    (tick_coins),
    .mode_now (tick_mode)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        a_valid <= 1'b1;
      end else if (a_fire) begin
        a_valid <= 1'b0;
      end
      if (a_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_perch  <= perch_pressed;
      a_strike <= coin_strike;
      a_button <= mode_button;
    end
    if (a_fire) begin
      gate_open     <= tick_flags.gate_open;
      gate_opened   <= tick_flags.gate_opened;
      gate_closed   <= tick_flags.gate_closed;
      bird_present  <= tick_flags.bird_present;
      bird_landed   <= tick_flags.bird_landed;
      coin_accepted <= tick_flags.coin_accepted;
      coins_pending <= tick_coins;
      mode          <= tick_mode;
    end
  end

  // A tick that fires always leaves a result behind it.
  assert property (@(posedge clk) disable iff (rst) a_fire |=> out_valid)
    else $error("tick fired without a result");

  // An opening pulse means the gate ends the tick open.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && gate_opened) |-> gate_open)
    else $error("gate opened but reported closed");

  // A close that is not followed by a reopening leaves the gate shut.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && gate_closed && !gate_opened) |-> !gate_open)
    else $error("gate closed but reported open");

  // Results carry only legal training modes.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mode >= crgc_pkg::MODE_FREE) && (mode <= crgc_pkg::MODE_COIN2))
    else $error("illegal mode in result");

  // The input side only waits when a tick is held in the input register.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> a_valid)
    else $error("input stalled with empty input register");

endmodule
